>>> hdl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// shared types, opcodes and constants for the voice allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int DEF_VOICE_COUNT = 32;
  localparam int DEF_PART_COUNT  = 4;
  localparam int DEF_LANE_COUNT  = 16;

  localparam int IN_W  = 40;   // 39 bits of fields padded to bytes
  localparam int OUT_W = 112;  // 105 bits of fields padded to bytes

  localparam logic [9:0] VEL_FLOOR = 10'd20;

  typedef enum logic [2:0] {
    OP_NOTE_ON    = 3'd0,
    OP_NOTE_OFF   = 3'd1,
    OP_LANE_ON    = 3'd2,
    OP_LANE_OFF   = 3'd3,
    OP_SUSTAIN    = 3'd4,
    OP_LANE_UPD   = 3'd5,
    OP_ALL_OFF    = 3'd6,
    OP_FINISHED   = 3'd7
  } op_t;

  typedef enum logic {
    REG_DETUNE_SCALE = 1'b0,
    REG_PART_ARTIC   = 1'b1
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic       apply;     // commit state change
    op_t        op;
    logic [1:0] part;
    logic [3:0] lane;
    logic [6:0] note;
    logic [3:0] artic;
    logic       sus;
    logic       part_sus;  // current sustain of the part
    logic       sus_drop;  // sustain goes 1 to 0
    logic       alloc;     // this item allocates
    logic [4:0] alloc_idx;
    logic       lane_on;
    logic [4:0] vid;
  } cell_cmd_t;

  // per cell status
  typedef struct packed {
    logic rel;
    logic upd;
  } cell_stat_t;

endpackage

`default_nettype wire

>>> hdl/polyphonic_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_unit
// voice table for a polyphonic synth built as a row of voice cells
// ----------------------------------------------------------------------------
// A request is accepted in the idle cycle and then passes a scan cycle in
// which first-free and first-carry tokens ripple through the row of voice
// cells and the humanize hash is reduced, an apply cycle that commits the
// cell updates and loads the result register, and the output cycle in
// which the result is offered. The next request is taken once the result
// is handed over; an output stall stretches the output cycle. Rejected
// requests give an all-zero result and change nothing.
`default_nettype none

module polyphonic_voice_allocator_unit #(
  parameter int VOICE_COUNT = pva_pkg::DEF_VOICE_COUNT,
  parameter int PART_COUNT  = pva_pkg::DEF_PART_COUNT,
  parameter int LANE_COUNT  = pva_pkg::DEF_LANE_COUNT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // opcode[2:0] part[5:3] lane[10:6] note[17:11] velocity[27:18]
  // articulation[31:28] sustain_flag[32] gesture_flag[33] voice_id[38:34]
  input  wire logic [pva_pkg::IN_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // accepted[0] voice_index[5:1] stolen[6] detune_q8[20:7] velocity_out[30:21]
  // articulation_out[34:31] carry_valid[35] carry_voice[40:36]
  // released_mask[72:41] updated_mask[104:73], zero above
  output logic [pva_pkg::OUT_W-1:0]     m_axis_tdata,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [15:0]              cfg_data
);
  import pva_pkg::*;

  state_t state, state_next;

  // configuration registers
  logic [9:0]  detune_scale;
  logic [15:0] part_artic;

  always_ff @(posedge clk) begin
    if (rst) begin
      detune_scale <= '0;
      part_artic   <= '0;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_DETUNE_SCALE: detune_scale <= cfg_data[9:0];
        REG_PART_ARTIC:   part_artic   <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured request
  logic [IN_W-1:0] req;
  op_t         op;
  logic [2:0]  part;
  logic [4:0]  lane, vid;
  logic [6:0]  note;
  logic [9:0]  vel;
  logic [3:0]  artic;
  logic        sus, gest;
  assign op    = op_t'(req[2:0]);
  assign part  = req[5:3];
  assign lane  = req[10:6];
  assign note  = req[17:11];
  assign vel   = req[27:18];
  assign artic = req[31:28];
  assign sus   = req[32];
  assign gest  = req[33];
  assign vid   = req[38:34];

  logic part_ok, lane_ok, ok;
  always_comb begin
    part_ok = 32'(part) < PART_COUNT;
    lane_ok = 32'(lane) < LANE_COUNT;
    unique case (op)
      OP_NOTE_ON, OP_NOTE_OFF, OP_SUSTAIN: ok = part_ok;
      OP_LANE_ON, OP_LANE_OFF:             ok = part_ok && lane_ok;
      OP_LANE_UPD:                         ok = lane_ok;
      OP_ALL_OFF:                          ok = 1'b1;
      default:                             ok = 32'(vid) < VOICE_COUNT;
    endcase
  end

  // part sustain flags
  logic [3:0] part_sus;

  // hash reduction: h <= 17*3+7*127+3*15 = 985; h mod 11 by reciprocal
  logic [9:0]  hash;
  logic [9:0]  quot;
  logic [10:0] rem_w;
  logic signed [4:0]  step;
  logic signed [4:0]  step_r;
  always_comb begin
    hash  = 10'(part) * 10'd17 + 10'(note) * 10'd7
            + (op == OP_LANE_ON ? 10'(lane) * 10'd3 : 10'd0);
    quot  = 10'((20'(hash) * 20'd745) >> 13);
    rem_w = 11'(hash) - 11'(quot) * 11'd11;
    if (rem_w >= 11'd11) rem_w = rem_w - 11'd11;
    step  = 5'(signed'({1'b0, rem_w[3:0]})) - 5'sd5;
  end

  // cell row
  cell_cmd_t  cmd;
  cell_stat_t stat [VOICE_COUNT];
  logic       free_c  [VOICE_COUNT+1];
  logic [4:0] free_i  [VOICE_COUNT+1];
  logic       carry_c [VOICE_COUNT+1];
  logic [4:0] carry_i [VOICE_COUNT+1];
  logic       alloc_op;

  assign free_c[0]  = 1'b0;
  assign free_i[0]  = '0;
  assign carry_c[0] = 1'b0;
  assign carry_i[0] = '0;

  logic       free_r, carry_r;
  logic [4:0] free_idx_r, carry_idx_r;

  assign alloc_op = ok && (op == OP_NOTE_ON || op == OP_LANE_ON);

  always_comb begin
    cmd.apply     = state == ST_APPLY && ok;
    cmd.op        = op;
    cmd.part      = part[1:0];
    cmd.lane      = lane[3:0];
    cmd.note      = note;
    cmd.artic     = op == OP_NOTE_ON ? part_artic[4*part[1:0] +: 4] : artic;
    cmd.sus       = sus;
    cmd.part_sus  = part_sus[part[1:0]];
    cmd.sus_drop  = part_sus[part[1:0]] && !sus;
    cmd.alloc     = alloc_op;
    cmd.alloc_idx = free_r ? free_idx_r : 5'd0;
    cmd.lane_on   = op == OP_LANE_ON;
    cmd.vid       = vid;
  end

  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
    pva_cell u_cell (
      .clk, .rst,
      .idx          (5'(g)),
      .cmd,
      .free_in      (free_c[g]),
      .free_idx_in  (free_i[g]),
      .free_out     (free_c[g+1]),
      .free_idx_out (free_i[g+1]),
      .carry_in     (carry_c[g]),
      .carry_idx_in (carry_i[g]),
      .carry_out    (carry_c[g+1]),
      .carry_idx_out(carry_i[g+1]),
      .stat         (stat[g])
    );
  end

  logic [31:0] rel_mask, upd_mask;
  always_comb begin
    rel_mask = '0;
    upd_mask = '0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      rel_mask[i] = stat[i].rel;
      upd_mask[i] = stat[i].upd;
    end
  end

  // result fields
  logic               r_acc, r_stolen, r_carry;
  logic [4:0]         r_vidx, r_cidx;
  logic signed [13:0] r_det;
  logic [9:0]         r_vel;
  logic [3:0]         r_artic;
  logic [31:0]        r_rel, r_upd;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_SCAN;
      ST_SCAN:  state_next = ST_APPLY;
      ST_APPLY: state_next = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_axis_tready = state == ST_IDLE;
  assign m_axis_tvalid = state == ST_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_sus <= '0;
    end else if (cmd.apply && op == OP_SUSTAIN) begin
      part_sus[part[1:0]] <= sus;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) req <= s_axis_tdata;
    if (state == ST_SCAN) begin
      free_r      <= free_c[VOICE_COUNT];
      free_idx_r  <= free_i[VOICE_COUNT];
      carry_r     <= carry_c[VOICE_COUNT] && gest && op == OP_LANE_ON && ok;
      carry_idx_r <= carry_i[VOICE_COUNT];
      step_r      <= step;
    end
    if (state == ST_APPLY) begin
      r_acc    <= ok;
      r_stolen <= alloc_op && !free_r;
      r_vidx   <= alloc_op ? cmd.alloc_idx : 5'd0;
      r_det    <= alloc_op ? 14'(step_r * signed'({1'b0, detune_scale})) : 14'sd0;
      r_vel    <= alloc_op ? (vel < VEL_FLOOR ? VEL_FLOOR : vel) : 10'd0;
      r_artic  <= alloc_op ? cmd.artic : 4'd0;
      r_carry  <= carry_r;
      r_cidx   <= carry_r ? carry_idx_r : 5'd0;
      r_rel    <= ok ? rel_mask : 32'd0;
      r_upd    <= ok ? upd_mask : 32'd0;
    end
  end

  assign m_axis_tdata = {7'b0000000, r_upd, r_rel, r_cidx, r_carry, r_artic, r_vel,
                         r_det, r_stolen, r_vidx, r_acc};

endmodule

`default_nettype wire

>>> hdl/pva_cell.sv
// ----------------------------------------------------------------------------
// pva_cell
// one voice slot; passes first-free and first-carry search tokens along
// ----------------------------------------------------------------------------
`default_nettype none

module pva_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [4:0]         idx,
  input  wire pva_pkg::cell_cmd_t cmd,
  input  wire logic               free_in,   // free voice found before this cell
  input  wire logic [4:0]         free_idx_in,
  output logic                    free_out,
  output logic [4:0]              free_idx_out,
  input  wire logic               carry_in,
  input  wire logic [4:0]         carry_idx_in,
  output logic                    carry_out,
  output logic [4:0]              carry_idx_out,
  output pva_pkg::cell_stat_t     stat
);
  import pva_pkg::*;

  logic       active, lane_valid, key_rel, releasing, local_sus;
  logic [6:0] note;
  logic [1:0] part;
  logic [3:0] lane, artic;
  logic       hit_off, hit_lane_off, hit_sus, hit_upd, hit_carry, rel_now;

  always_comb begin
    hit_off      = active && part == cmd.part && !lane_valid && note == cmd.note;
    hit_lane_off = active && part == cmd.part && lane_valid && lane == cmd.lane
                   && note == cmd.note;
    hit_carry    = active && part == cmd.part && lane_valid && lane == cmd.lane;
    hit_sus      = active && part == cmd.part && key_rel && cmd.sus_drop;
    hit_upd      = active && lane_valid && lane == cmd.lane;
    rel_now      = 1'b0;
    unique case (cmd.op)
      OP_NOTE_OFF: rel_now = hit_off && !cmd.part_sus;
      OP_LANE_OFF: rel_now = hit_lane_off && !local_sus;
      OP_SUSTAIN:  rel_now = hit_sus;
      OP_ALL_OFF:  rel_now = active;
      default:     rel_now = 1'b0;
    endcase
    rel_now = rel_now && !releasing;

    free_out      = free_in || !active;
    free_idx_out  = free_in ? free_idx_in : idx;
    carry_out     = carry_in || hit_carry;
    carry_idx_out = carry_in ? carry_idx_in : idx;

    stat.rel       = rel_now;
    stat.upd       = cmd.op == OP_LANE_UPD && hit_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0; lane_valid <= 1'b0; key_rel <= 1'b0;
      releasing <= 1'b0; local_sus <= 1'b0;
      note <= '0; part <= '0; lane <= '0; artic <= '0;
    end else if (cmd.apply) begin
      if (cmd.alloc && cmd.alloc_idx == idx) begin
        active     <= 1'b1;
        note       <= cmd.note;
        part       <= cmd.part;
        lane_valid <= cmd.lane_on;
        lane       <= cmd.lane_on ? cmd.lane : 4'd0;
        key_rel    <= 1'b0;
        releasing  <= 1'b0;
        local_sus  <= cmd.lane_on ? cmd.sus : 1'b0;
        artic      <= cmd.artic;
      end else begin
        if (rel_now) releasing <= 1'b1;
        if ((cmd.op == OP_NOTE_OFF && hit_off) ||
            (cmd.op == OP_LANE_OFF && hit_lane_off)) key_rel <= 1'b1;
        if (stat.upd) begin
          local_sus <= cmd.sus;
          artic     <= cmd.artic;
        end
        if (cmd.op == OP_FINISHED && cmd.vid == idx && active && releasing)
          active <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
